### design/lpes_pkg.sv
// Shared types, codes and constants of the Lennard-Jones point energy block.
// Used by the interfaces, the site memory, the arithmetic unit and the top level.
`default_nettype none
package lpes_pkg;

  localparam int MAX_SITES_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam int ARITH_W = 64;
  localparam int CNT_W = 6;
  localparam int VAL_W = 40;

  localparam logic [63:0] SAT_VAL = 64'd1 << 39;
  localparam logic [63:0] K4R = 64'd142841380;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RCUT2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_POW6 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_POW12 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_CAP = 2'd3;

  localparam logic [31:0] RCUT2_RST = 32'd9437184;
  localparam logic [31:0] INV_POW6_RST = 32'd0;
  localparam logic [31:0] INV_POW12_RST = 32'd0;
  localparam logic [30:0] ENERGY_CAP_RST = 31'd163840000;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_EVAL = 2'd2
  } action_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] depth;
    logic [31:0] s6;
  } site_t;

  typedef enum logic {
    AOP_MUL,
    AOP_DIV
  } arith_op_t;

  typedef struct packed {
    logic start;
    arith_op_t op;
    logic [ARITH_W-1:0] a;
    logic [ARITH_W-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [ARITH_W-1:0] result;
  } arith_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ISSUE,
    S_WAIT,
    S_CHECK,
    S_ACCUM,
    S_NEXT,
    S_OUT
  } state_t;

  typedef enum logic [3:0] {
    PH_SQX,
    PH_SQY,
    PH_SQZ,
    PH_Q1,
    PH_Q2,
    PH_U,
    PH_UC,
    PH_T,
    PH_UC12,
    PH_U2,
    PH_P,
    PH_M
  } phase_t;

endpackage
`default_nettype wire

### design/lpes_ifs.sv
// Handshake channels of the block: input items, results and configuration writes.
// Depends on lpes_pkg for the register index width.
`default_nettype none
interface lpes_item_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0] well_depth;
  logic [31:0] sigma_pow6;
  modport source(output valid, action, pos_x, pos_y, pos_z, well_depth, sigma_pow6,
                 input ready);
  modport sink(input valid, action, pos_x, pos_y, pos_z, well_depth, sigma_pow6,
               output ready);
endinterface

interface lpes_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] energy;
  logic capped;
  modport source(output valid, energy, capped, input ready);
  modport sink(input valid, energy, capped, output ready);
endinterface

interface lpes_cfg_if;
  logic valid;
  logic ready;
  logic [lpes_pkg::CFG_IDX_W-1:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/lpes_site_mem.sv
// Site table: one synchronous memory of site records with a registered read port.
// Depends on lpes_pkg for the site record type.
`default_nettype none
module lpes_site_mem #(
  parameter int DEPTH = lpes_pkg::MAX_SITES_DEF,
  parameter int AW = 10
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire lpes_pkg::site_t wdata,
  input wire logic re,
  input wire logic [AW-1:0] raddr,
  output lpes_pkg::site_t rdata
);

  lpes_pkg::site_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/lpes_arith.sv
// Serial arithmetic unit: 64 by 64 saturating multiply or saturating fixed-point divide,
// one bit per cycle. Depends on lpes_pkg for its request and response types.
`default_nettype none
module lpes_arith (
  input wire logic clk,
  input wire logic rst,
  input wire lpes_pkg::arith_req_t req,
  output lpes_pkg::arith_rsp_t rsp
);

  logic running;
  logic done;
  logic [lpes_pkg::CNT_W-1:0] cnt;
  lpes_pkg::arith_op_t op;
  logic [lpes_pkg::ARITH_W-1:0] opa;
  logic [lpes_pkg::ARITH_W-1:0] opb;
  logic [2*lpes_pkg::ARITH_W-1:0] acc;
  logic [2*lpes_pkg::ARITH_W-1:0] acc_next;
  logic [lpes_pkg::ARITH_W:0] rem_sh;
  logic [lpes_pkg::ARITH_W:0] diff;
  logic [lpes_pkg::ARITH_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt <= '1;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      opa <= req.a;
      opb <= req.b;
      acc <= (req.op == lpes_pkg::AOP_DIV) ? {64'd0, req.a} : '0;
    end else if (running) begin
      acc <= acc_next;
      if (op == lpes_pkg::AOP_MUL) begin
        opb <= {opb[62:0], 1'b0};
      end
    end
  end

  always_comb begin
    rem_sh = acc[127:63];
    diff = rem_sh - {1'b0, opb};
    if (op == lpes_pkg::AOP_MUL) begin
      acc_next = {acc[126:0], 1'b0} + (opb[63] ? {64'd0, opa} : 128'd0);
    end else if (rem_sh >= {1'b0, opb}) begin
      acc_next = {diff[63:0], acc[62:0], 1'b1};
    end else begin
      acc_next = {acc[126:0], 1'b0};
    end
  end

  always_comb begin
    quot = acc[63:0];
    rsp.busy = running;
    rsp.done = done;
    if (op == lpes_pkg::AOP_MUL) begin
      rsp.result = (acc[127:64] != '0) ? '1 : acc[63:0];
    end else if (opb == '0 || quot > lpes_pkg::SAT_VAL) begin
      rsp.result = lpes_pkg::SAT_VAL;
    end else begin
      rsp.result = quot;
    end
  end

endmodule
`default_nettype wire

### design/lj_point_energy_sum.sv
// Clear and append items leave the block in its idle state, so it stays ready for more.
// An evaluate walks the stored sites one after another through the serial unit and stops
// early once the sum passes the energy cap: a site beyond the cutoff takes three operations
// and a site inside it takes twelve, after which the result is posted.
// Reset empties the site table and loads the register defaults; there is no clearing pass.
// Depends on lpes_pkg, lpes_ifs, lpes_site_mem and lpes_arith.
`default_nettype none
module lj_point_energy_sum #(
  parameter int MAX_SITES = lpes_pkg::MAX_SITES_DEF,
  parameter int FRAC_BITS = lpes_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lpes_item_if.sink item,
  lpes_result_if.source result,
  lpes_cfg_if.sink cfg
);

  localparam int CW = $clog2(MAX_SITES + 1);
  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int VW = lpes_pkg::VAL_W;

  lpes_pkg::state_t state;
  lpes_pkg::state_t state_next;
  lpes_pkg::phase_t phase;
  lpes_pkg::phase_t phase_next;

  logic [31:0] rcut2;
  logic [31:0] inv_pow6;
  logic [31:0] inv_pow12;
  logic [30:0] energy_cap;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [31:0] probe_x;
  logic [31:0] probe_y;
  logic [31:0] probe_z;
  logic [63:0] d2;
  logic [VW-1:0] q;
  logic [VW-1:0] u;
  logic [31:0] uc;
  logic [31:0] t;
  logic [VW-1:0] uc12;
  logic [VW-1:0] u2;
  logic [63:0] p;
  logic [VW-1:0] m;
  logic signed [31:0] sum;
  logic cap_flag;
  logic res_valid;
  logic signed [31:0] res_energy;
  logic res_capped;

  logic accept;
  logic mem_we;
  logic mem_re;
  lpes_pkg::site_t wsite;
  lpes_pkg::site_t site;
  lpes_pkg::arith_req_t areq;
  lpes_pkg::arith_rsp_t arsp;

  logic [31:0] abs_x;
  logic [31:0] abs_y;
  logic [31:0] abs_z;
  logic signed [41:0] b_val;
  logic b_neg;
  logic [41:0] b_mag;
  logic signed [41:0] contrib;
  logic signed [41:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic cap_hit;
  logic [63:0] res_f;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] s);
    logic signed [32:0] dv;
    begin
      dv = $signed({a[31], a}) - $signed({s[31], s});
      abs_diff = dv[32] ? 32'(-dv) : dv[31:0];
    end
  endfunction

  function automatic logic [VW-1:0] sat_val(input logic [63:0] x);
    begin
      sat_val = (x > lpes_pkg::SAT_VAL) ? lpes_pkg::SAT_VAL[VW-1:0] : x[VW-1:0];
    end
  endfunction

  function automatic logic [63:0] div_num(input logic [VW-1:0] x);
    begin
      div_num = {24'd0, x} << FRAC_BITS;
    end
  endfunction

  assign accept = item.valid && item.ready;
  assign cfg.ready = 1'b1;
  assign result.valid = res_valid;
  assign result.energy = res_energy;
  assign result.capped = res_capped;

  assign wsite = '{px: item.pos_x, py: item.pos_y, pz: item.pos_z,
                   depth: item.well_depth, s6: item.sigma_pow6};
  assign mem_we = accept && item.action == lpes_pkg::ACT_APPEND &&
                  count < CW'(MAX_SITES);

  lpes_site_mem #(.DEPTH(MAX_SITES), .AW(AW)) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(count[AW-1:0]),
    .wdata(wsite),
    .re(mem_re),
    .raddr(idx[AW-1:0]),
    .rdata(site)
  );

  lpes_arith u_arith (
    .clk(clk),
    .rst(rst),
    .req(areq),
    .rsp(arsp)
  );

  assign abs_x = abs_diff(probe_x, site.px);
  assign abs_y = abs_diff(probe_y, site.py);
  assign abs_z = abs_diff(probe_z, site.pz);
  assign res_f = arsp.result >> FRAC_BITS;

  assign b_val = $signed({2'b00, u2}) - $signed({2'b00, u}) - $signed({2'b00, uc12}) +
                 $signed({10'd0, uc});
  assign b_neg = b_val[41];
  assign b_mag = b_neg ? 42'(-b_val) : 42'(b_val);
  assign contrib = b_neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  assign sum_wide = $signed({{10{sum[31]}}, sum}) + contrib;
  always_comb begin
    if (sum_wide > 42'sd2147483647) begin
      sum_sat = 32'sh7fffffff;
    end else if (sum_wide < -42'sd2147483648) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end
  assign cap_hit = $signed({{10{sum_sat[31]}}, sum_sat}) > $signed({11'd0, energy_cap});

  always_comb begin
    case (phase)
      lpes_pkg::PH_SQX: phase_next = lpes_pkg::PH_SQY;
      lpes_pkg::PH_SQY: phase_next = lpes_pkg::PH_SQZ;
      lpes_pkg::PH_SQZ: phase_next = lpes_pkg::PH_Q1;
      lpes_pkg::PH_Q1: phase_next = lpes_pkg::PH_Q2;
      lpes_pkg::PH_Q2: phase_next = lpes_pkg::PH_U;
      lpes_pkg::PH_U: phase_next = lpes_pkg::PH_UC;
      lpes_pkg::PH_UC: phase_next = lpes_pkg::PH_T;
      lpes_pkg::PH_T: phase_next = lpes_pkg::PH_UC12;
      lpes_pkg::PH_UC12: phase_next = lpes_pkg::PH_U2;
      lpes_pkg::PH_U2: phase_next = lpes_pkg::PH_P;
      lpes_pkg::PH_P: phase_next = lpes_pkg::PH_M;
      default: phase_next = lpes_pkg::PH_SQX;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      lpes_pkg::S_IDLE: begin
        if (accept && item.action == lpes_pkg::ACT_EVAL) begin
          state_next = (count == '0) ? lpes_pkg::S_OUT : lpes_pkg::S_READ;
        end
      end
      lpes_pkg::S_READ: state_next = lpes_pkg::S_ISSUE;
      lpes_pkg::S_ISSUE: state_next = lpes_pkg::S_WAIT;
      lpes_pkg::S_WAIT: begin
        if (arsp.done) begin
          if (phase == lpes_pkg::PH_SQZ) begin
            state_next = lpes_pkg::S_CHECK;
          end else if (phase == lpes_pkg::PH_M) begin
            state_next = lpes_pkg::S_ACCUM;
          end else begin
            state_next = lpes_pkg::S_ISSUE;
          end
        end
      end
      lpes_pkg::S_CHECK: begin
        state_next = (d2 >= {32'd0, rcut2}) ? lpes_pkg::S_NEXT : lpes_pkg::S_ISSUE;
      end
      lpes_pkg::S_ACCUM: state_next = cap_hit ? lpes_pkg::S_OUT : lpes_pkg::S_NEXT;
      lpes_pkg::S_NEXT: begin
        state_next = (idx + 1'b1 == count) ? lpes_pkg::S_OUT : lpes_pkg::S_READ;
      end
      lpes_pkg::S_OUT: begin
        if (!res_valid || result.ready) begin
          state_next = lpes_pkg::S_IDLE;
        end
      end
      default: state_next = lpes_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == lpes_pkg::S_IDLE);
    mem_re = (state == lpes_pkg::S_READ);
    areq.start = (state == lpes_pkg::S_ISSUE);
    areq.op = lpes_pkg::AOP_MUL;
    areq.a = '0;
    areq.b = '0;
    case (phase)
      lpes_pkg::PH_SQX: begin
        areq.a = {32'd0, abs_x};
        areq.b = {32'd0, abs_x};
      end
      lpes_pkg::PH_SQY: begin
        areq.a = {32'd0, abs_y};
        areq.b = {32'd0, abs_y};
      end
      lpes_pkg::PH_SQZ: begin
        areq.a = {32'd0, abs_z};
        areq.b = {32'd0, abs_z};
      end
      lpes_pkg::PH_Q1: begin
        areq.op = lpes_pkg::AOP_DIV;
        areq.a = div_num({8'd0, site.s6});
        areq.b = d2;
      end
      lpes_pkg::PH_Q2, lpes_pkg::PH_U: begin
        areq.op = lpes_pkg::AOP_DIV;
        areq.a = div_num(q);
        areq.b = d2;
      end
      lpes_pkg::PH_UC: begin
        areq.a = {32'd0, site.s6};
        areq.b = {32'd0, inv_pow6};
      end
      lpes_pkg::PH_T: begin
        areq.a = {32'd0, site.s6};
        areq.b = {32'd0, inv_pow12};
      end
      lpes_pkg::PH_UC12: begin
        areq.a = {32'd0, t};
        areq.b = {32'd0, site.s6};
      end
      lpes_pkg::PH_U2: begin
        areq.a = {24'd0, u};
        areq.b = {24'd0, u};
      end
      lpes_pkg::PH_P: begin
        areq.a = {32'd0, site.depth};
        areq.b = {22'd0, b_mag};
      end
      lpes_pkg::PH_M: begin
        areq.a = p;
        areq.b = lpes_pkg::K4R;
      end
      default: begin
        areq.a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpes_pkg::S_IDLE;
      phase <= lpes_pkg::PH_SQX;
      count <= '0;
      idx <= '0;
      rcut2 <= lpes_pkg::RCUT2_RST;
      inv_pow6 <= lpes_pkg::INV_POW6_RST;
      inv_pow12 <= lpes_pkg::INV_POW12_RST;
      energy_cap <= lpes_pkg::ENERGY_CAP_RST;
      res_valid <= 1'b0;
      sum <= '0;
      cap_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          lpes_pkg::CFG_RCUT2: rcut2 <= cfg.data;
          lpes_pkg::CFG_INV_POW6: inv_pow6 <= cfg.data;
          lpes_pkg::CFG_INV_POW12: inv_pow12 <= cfg.data;
          lpes_pkg::CFG_ENERGY_CAP: energy_cap <= cfg.data[30:0];
          default: rcut2 <= rcut2;
        endcase
      end
      if (accept) begin
        case (lpes_pkg::action_t'(item.action))
          lpes_pkg::ACT_CLEAR: count <= '0;
          lpes_pkg::ACT_APPEND: begin
            if (mem_we) begin
              count <= count + 1'b1;
            end
          end
          lpes_pkg::ACT_EVAL: begin
            idx <= '0;
            sum <= '0;
            cap_flag <= 1'b0;
          end
          default: count <= count;
        endcase
      end
      if (state == lpes_pkg::S_READ) begin
        phase <= lpes_pkg::PH_SQX;
      end
      if (state == lpes_pkg::S_WAIT && arsp.done) begin
        phase <= phase_next;
      end
      if (state == lpes_pkg::S_ACCUM) begin
        sum <= sum_sat;
        cap_flag <= cap_hit;
      end
      if (state == lpes_pkg::S_NEXT) begin
        idx <= idx + 1'b1;
      end
      if (state == lpes_pkg::S_OUT && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      probe_x <= item.pos_x;
      probe_y <= item.pos_y;
      probe_z <= item.pos_z;
    end
    if (state == lpes_pkg::S_OUT && (!res_valid || result.ready)) begin
      res_energy <= sum;
      res_capped <= cap_flag;
    end
    if (state == lpes_pkg::S_WAIT && arsp.done) begin
      case (phase)
        lpes_pkg::PH_SQX: d2 <= res_f;
        lpes_pkg::PH_SQY, lpes_pkg::PH_SQZ: d2 <= d2 + res_f;
        lpes_pkg::PH_Q1, lpes_pkg::PH_Q2: q <= arsp.result[VW-1:0];
        lpes_pkg::PH_U: u <= arsp.result[VW-1:0];
        lpes_pkg::PH_UC: uc <= arsp.result[63:32];
        lpes_pkg::PH_T: t <= arsp.result[63:32];
        lpes_pkg::PH_UC12: uc12 <= sat_val(res_f);
        lpes_pkg::PH_U2: u2 <= sat_val(res_f);
        lpes_pkg::PH_P: p <= res_f;
        lpes_pkg::PH_M: m <= sat_val({32'd0, arsp.result[63:32]});
        default: p <= p;
      endcase
    end
  end

  a_arith_idle: assert property (@(posedge clk) disable iff (rst)
    areq.start |-> !arsp.busy)
    else $error("arithmetic unit started while busy");

  a_read_in_table: assert property (@(posedge clk) disable iff (rst)
    state == lpes_pkg::S_READ |-> idx < count)
    else $error("site read beyond the filled table");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SITES))
    else $error("site count past table depth");

  a_cap_meaning: assert property (@(posedge clk) disable iff (rst)
    (state == lpes_pkg::S_OUT && cap_flag) |->
      $signed({1'b0, sum}) > $signed({2'b00, energy_cap}))
    else $error("capped flag set with sum not above cap");

endmodule
`default_nettype wire
